[hw/rtl/bernoulli_naive_bayes_trainer_top_defines.svh]
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes trainer - assertion macros
// Shared property wrappers for the trainer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BERNOULLI_NAIVE_BAYES_TRAINER_TOP_DEFINES_SVH
`define BERNOULLI_NAIVE_BAYES_TRAINER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while reset is low
`define BNBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while reset is low
`define BNBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bnbt_pkg.sv]
// ----------------------------------------------------------------------------
// bnbt_pkg
// Types and constants of the Bernoulli naive Bayes trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package bnbt_pkg;

  // Default geometry
  localparam int unsigned IMAGE_SIDE_DEF  = 28;
  localparam int unsigned NUM_CLASSES_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned LABEL_W = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned PROB_W  = 17;
  localparam int unsigned SEEN_W  = 10;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [PROB_W-1:0] ONE_Q16  = PROB_W'(65536);

  // Request operation codes
  localparam logic [OP_W-1:0] OP_TRAIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_PRIOR  = 2'd1;
  localparam logic [OP_W-1:0] OP_LIKELY = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/bernoulli_naive_bayes_trainer_top.sv]
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid tready tdata tuser    train pixel or query request
//                tlast
// m_axis    out  tvalid tready tdata tuser    probability answer
//
// Train request: accept, count memory read, write back.
// Query request: accept, read, operand setup, 17 divider steps, output load;
// a query answered with zero skips the divider.
// After reset a clearing pass zeroes the count memory, one entry per cycle
// (NUM_CLASSES*IMAGE_SIDE*IMAGE_SIDE entries, 7840 by default).
// An answer waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes trainer
// Counts shaded pixels per class and position in one synchronous memory
// and answers class prior and pixel likelihood queries in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bernoulli_naive_bayes_trainer_top_defines.svh"

module bernoulli_naive_bayes_trainer_top #(
  parameter int unsigned IMAGE_SIDE  = bnbt_pkg::IMAGE_SIDE_DEF,
  parameter int unsigned NUM_CLASSES = bnbt_pkg::NUM_CLASSES_DEF,
  parameter int unsigned COUNT_BITS  = bnbt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: label[3:0], row[9:4], col[15:10], shaded[16], zero[23:17]
  input  wire logic [bnbt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [bnbt_pkg::OP_W-1:0]       s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  // answer channel
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: probability[16:0], zero[23:17]
  output logic [bnbt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: is_prior[0]
  output logic [0:0]                           m_axis_tuser
);

  localparam int unsigned CELLS  = NUM_CLASSES * IMAGE_SIDE * IMAGE_SIDE;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned DEN_W  =
    ((COUNT_BITS > bnbt_pkg::SEEN_W) ? COUNT_BITS : bnbt_pkg::SEEN_W) + 1;
  localparam int unsigned STEPS  = bnbt_pkg::PROB_W;
  localparam int unsigned STEP_W = $clog2(STEPS);

  localparam logic [CB-1:0]     CNT_MAX  = '1;
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(CELLS - 1);
  localparam logic [STEP_W-1:0] LAST_STP = STEP_W'(STEPS - 1);

  // Request fields
  logic [bnbt_pkg::OP_W-1:0]    op_in;
  logic [bnbt_pkg::LABEL_W-1:0] label_in;
  logic [bnbt_pkg::POS_W-1:0]   row_in, col_in;
  logic                         lab_ok_in, pos_ok_in;
  logic [ADDR_W-1:0]            idx_in;

  assign op_in    = s_axis_tuser;
  assign label_in = s_axis_tdata[3:0];
  assign row_in   = s_axis_tdata[9:4];
  assign col_in   = s_axis_tdata[15:10];

  assign lab_ok_in = ({1'b0, label_in} < (bnbt_pkg::LABEL_W + 1)'(NUM_CLASSES));
  assign pos_ok_in = ({1'b0, row_in} < (bnbt_pkg::POS_W + 1)'(IMAGE_SIDE)) &&
                     ({1'b0, col_in} < (bnbt_pkg::POS_W + 1)'(IMAGE_SIDE));

  // Flat memory address (class, row, col)
  assign idx_in = (ADDR_W'(label_in) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(row_in))
                  * ADDR_W'(IMAGE_SIDE) + ADDR_W'(col_in);

  // State
  bnbt_pkg::state_e state_q, state_d;

  logic [bnbt_pkg::OP_W-1:0]    op_q;
  logic [bnbt_pkg::LABEL_W-1:0] label_q;
  logic                         shaded_q, last_q, lab_ok_q, pos_ok_q;
  logic [ADDR_W-1:0]            idx_q;
  logic [ADDR_W-1:0]            clr_q;

  logic [CB-1:0]                cls_cnt_q [NUM_CLASSES];
  logic [CB-1:0]                total_q;
  logic [bnbt_pkg::SEEN_W-1:0]  seen_q;

  logic [CB-1:0]                mem [CELLS];
  logic [CB-1:0]                rd_q;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [CB-1:0]                mem_wd;

  logic [DEN_W-1:0]             rem_q, den_q;
  logic [bnbt_pkg::PROB_W-1:0]  quo_q;
  logic [STEP_W-1:0]            step_q;

  logic                         out_vld_q;
  logic [bnbt_pkg::PROB_W-1:0]  prob_q;
  logic                         prior_q;

  logic                         in_acc, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // Class image count of the held label
  logic [CB-1:0] n_c;
  assign n_c = lab_ok_q ? cls_cnt_q[label_q[CLS_W-1:0]] : '0;

  // Query operands
  logic [CB-1:0]    m_clip, m_sel;
  logic [DEN_W-1:0] num_pri, den_pri, num_lik, den_lik;
  logic             zero_ans;

  assign m_clip  = (rd_q > n_c) ? n_c : rd_q;
  assign m_sel   = shaded_q ? m_clip : n_c - m_clip;
  assign num_pri = DEN_W'(n_c) + DEN_W'(1);
  assign den_pri = DEN_W'(seen_q) + DEN_W'(total_q);
  assign num_lik = DEN_W'(m_sel) + DEN_W'(1);
  assign den_lik = DEN_W'(n_c) + DEN_W'(2);
  assign zero_ans = !lab_ok_q || (n_c == '0) ||
                    ((op_q == bnbt_pkg::OP_LIKELY) && !pos_ok_q);

  // Divider step: integer bit first, then 16 fraction bits
  logic [DEN_W:0] trial;
  logic           q_bit;
  assign trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign q_bit = (trial >= {1'b0, den_q});

  // Next state and memory write port
  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q;
    mem_wd  = (rd_q == CNT_MAX) ? CNT_MAX : rd_q + CB'(1);
    unique case (state_q)
      bnbt_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        if (clr_q == LAST_ADR) state_d = bnbt_pkg::ST_IDLE;
      end
      bnbt_pkg::ST_IDLE: begin
        if (in_acc) state_d = bnbt_pkg::ST_READ;
      end
      bnbt_pkg::ST_READ: begin
        state_d = bnbt_pkg::ST_EXEC;
      end
      bnbt_pkg::ST_EXEC: begin
        case (op_q) inside
          bnbt_pkg::OP_TRAIN: begin
            mem_we  = lab_ok_q && pos_ok_q && shaded_q;
            state_d = bnbt_pkg::ST_IDLE;
          end
          bnbt_pkg::OP_PRIOR, bnbt_pkg::OP_LIKELY: begin
            state_d = zero_ans ? bnbt_pkg::ST_RESULT : bnbt_pkg::ST_DIV;
          end
          default: state_d = bnbt_pkg::ST_IDLE;
        endcase
      end
      bnbt_pkg::ST_DIV: begin
        if (step_q == LAST_STP) state_d = bnbt_pkg::ST_RESULT;
      end
      bnbt_pkg::ST_RESULT: begin
        if (out_free) state_d = bnbt_pkg::ST_IDLE;
      end
      default: state_d = bnbt_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == bnbt_pkg::ST_IDLE);

  // State register and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bnbt_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bnbt_pkg::ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Count memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx_q];
  end

  // Held request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= op_in;
      label_q  <= label_in;
      shaded_q <= s_axis_tdata[16];
      last_q   <= s_axis_tlast;
      lab_ok_q <= lab_ok_in;
      pos_ok_q <= pos_ok_in;
      idx_q    <= pos_ok_in ? idx_in : '0;
    end
  end

  // Class counts, image total and classes seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) cls_cnt_q[i] <= '0;
      total_q <= '0;
      seen_q  <= '0;
    end else if (state_q == bnbt_pkg::ST_EXEC && op_q == bnbt_pkg::OP_TRAIN &&
                 lab_ok_q && last_q) begin
      if (n_c != CNT_MAX) cls_cnt_q[label_q[CLS_W-1:0]] <= n_c + CB'(1);
      if (total_q != CNT_MAX) total_q <= total_q + CB'(1);
      if (n_c == '0 && seen_q != bnbt_pkg::SEEN_MAX)
        seen_q <= seen_q + bnbt_pkg::SEEN_W'(1);
    end
  end

  // Shift-subtract divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == bnbt_pkg::ST_EXEC) begin
      step_q <= '0;
    end else if (state_q == bnbt_pkg::ST_DIV) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bnbt_pkg::ST_EXEC) begin
      quo_q <= '0;
      if (op_q == bnbt_pkg::OP_PRIOR) begin
        rem_q <= num_pri;
        den_q <= den_pri;
      end else begin
        rem_q <= num_lik;
        den_q <= den_lik;
      end
    end else if (state_q == bnbt_pkg::ST_DIV) begin
      quo_q <= {quo_q[bnbt_pkg::PROB_W-2:0], q_bit};
      rem_q <= q_bit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == bnbt_pkg::ST_RESULT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bnbt_pkg::ST_RESULT && out_free) begin
      prob_q  <= (quo_q > bnbt_pkg::ONE_Q16) ? bnbt_pkg::ONE_Q16 : quo_q;
      prior_q <= (op_q == bnbt_pkg::OP_PRIOR);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = bnbt_pkg::OUT_DATA_W'(prob_q);
  assign m_axis_tuser  = prior_q;

  // Checks
  `BNBT_ASSERT_NOW(a_prob_range, m_axis_tvalid, prob_q <= bnbt_pkg::ONE_Q16, "probability above one")
  `BNBT_ASSERT_NOW(a_class_le_total, state_q == bnbt_pkg::ST_EXEC && lab_ok_q, n_c <= total_q, "class count above total")
  `BNBT_ASSERT_NOW(a_div_rem, state_q == bnbt_pkg::ST_DIV && step_q != '0, rem_q < den_q, "divider remainder not below divisor")
  `BNBT_ASSERT_NEXT(a_train_no_answer, state_q == bnbt_pkg::ST_EXEC && op_q == bnbt_pkg::OP_TRAIN, state_q == bnbt_pkg::ST_IDLE, "training request did not finish")

endmodule

`default_nettype wire

[tb/bernoulli_naive_bayes_trainer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes trainer - testbench
// Streams training pixels and prior / likelihood queries into the trainer.
// Keeps its own copy of the pixel and image counts and computes every
// answer in Q1.16. It compares each answer field by field, in order, while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module bernoulli_naive_bayes_trainer_top_tb;
  import bnbt_pkg::*;

  localparam int unsigned IMAGE_SIDE  = IMAGE_SIDE_DEF;
  localparam int unsigned NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int unsigned COUNT_W     = COUNT_BITS_DEF;
  localparam int unsigned PIXEL_SLOTS = NUM_CLASSES * IMAGE_SIDE * IMAGE_SIDE;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation code that the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1260;
  localparam int unsigned BURST_IMAGES = 24;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LABEL_W-1:0] label;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               shaded;
    logic               last;
  } request_t;

  typedef struct {
    logic [PROB_W-1:0] prob;
    logic              is_prior;
  } answer_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // Stream ports
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = OP_TRAIN;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  bernoulli_naive_bayes_trainer_top #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_BITS (COUNT_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Trainer state as the testbench tracks it
  logic [COUNT_W-1:0] shaded_tally [PIXEL_SLOTS];
  logic [COUNT_W-1:0] class_images [NUM_CLASSES];
  logic [COUNT_W-1:0] images_total;
  logic [SEEN_W-1:0]  classes_seen_cnt;

  answer_t     expected_answers[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          pace_sender   = 1'b1;
  bit          pace_receiver = 1'b1;
  int unsigned rx_hold = 0;

  // Frequently trained positions, so that counts build up
  logic [POS_W-1:0] hot_row [8];
  logic [POS_W-1:0] hot_col [8];

  // Q1.16 quotient, truncated and capped at one
  function automatic logic [PROB_W-1:0] q16_fraction(input longint unsigned num,
                                                      input longint unsigned den);
    longint unsigned q;
    if (den == 0) return '0;
    q = (num << 16) / den;
    return (q > 65536) ? ONE_Q16 : PROB_W'(q);
  endfunction

  // Applies one request to the tracked state; returns 1 when it yields an answer
  function automatic bit predict_answer(input request_t r, output answer_t a);
    bit                 lab_ok;
    bit                 pos_ok;
    int unsigned        pos_index;
    logic [COUNT_W-1:0] n_c;
    logic [COUNT_W-1:0] m;
    lab_ok    = r.label < NUM_CLASSES;
    pos_ok    = (r.row < IMAGE_SIDE) && (r.col < IMAGE_SIDE);
    n_c       = lab_ok ? class_images[r.label] : '0;
    pos_index = (lab_ok && pos_ok) ? (r.label * IMAGE_SIDE + r.row) * IMAGE_SIDE + r.col : 0;
    a.prob     = '0;
    a.is_prior = 1'b0;
    case (r.op)
      OP_TRAIN: begin
        if (lab_ok) begin
          if (pos_ok && r.shaded && shaded_tally[pos_index] != COUNT_MAX)
            shaded_tally[pos_index] = shaded_tally[pos_index] + 1'b1;
          if (r.last) begin
            if (n_c == 0 && classes_seen_cnt != SEEN_MAX)
              classes_seen_cnt = classes_seen_cnt + 1'b1;
            if (n_c != COUNT_MAX) class_images[r.label] = n_c + 1'b1;
            if (images_total != COUNT_MAX) images_total = images_total + 1'b1;
          end
        end
        return 1'b0;
      end
      OP_PRIOR: begin
        a.is_prior = 1'b1;
        if (lab_ok && n_c != 0)
          a.prob = q16_fraction(64'(n_c) + 1, 64'(classes_seen_cnt) + 64'(images_total));
        return 1'b1;
      end
      OP_LIKELY: begin
        if (lab_ok && pos_ok && n_c != 0) begin
          // image still in progress: shaded count can exceed n_c
          m = (shaded_tally[pos_index] > n_c) ? n_c : shaded_tally[pos_index];
          if (!r.shaded) m = n_c - m;
          a.prob = q16_fraction(64'(m) + 1, 64'(n_c) + 2);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Sends one request and records what it should answer
  task automatic send_request(input request_t r);
    int unsigned gap;
    answer_t     a;
    gap = pace_sender ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tlast  <= r.last;
    s_axis_tdata  <= {7'b0, r.shaded, r.col, r.row, r.label};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_answer(r, a)) expected_answers.insert(expected_answers.size(), a);
  endtask

  task automatic send_fields(input logic [OP_W-1:0] op, input int unsigned label,
                             input int unsigned row, input int unsigned col,
                             input bit shaded, input bit last);
    request_t r;
    r.op     = op;
    r.label  = LABEL_W'(label);
    r.row    = POS_W'(row);
    r.col    = POS_W'(col);
    r.shaded = shaded;
    r.last   = last;
    send_request(r);
  endtask

  // Holds the sender off until every pending answer has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_position(output logic [POS_W-1:0] row, output logic [POS_W-1:0] col);
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, 7);
    if (sel < 75) begin
      row = hot_row[k];
      col = hot_col[k];
    end else if (sel < 90) begin
      row = POS_W'($urandom_range(0, IMAGE_SIDE - 1));
      col = POS_W'($urandom_range(0, IMAGE_SIDE - 1));
    end else begin
      row = POS_W'($urandom_range(0, 63));
      col = POS_W'($urandom_range(0, 63));
    end
  endtask

  // Answer checker: compares each accepted answer with the oldest prediction
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_answers.size() == 0) begin
        $error("answer with none pending: probability %0d is_prior %0d",
               m_axis_tdata[PROB_W-1:0], m_axis_tuser[0]);
        fail_count++;
      end else begin
        a = expected_answers.pop_front();
        if (m_axis_tdata[PROB_W-1:0] !== a.prob) begin
          $error("probability: expected %0d, got %0d", a.prob, m_axis_tdata[PROB_W-1:0]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== a.is_prior) begin
          $error("is_prior: expected %0d, got %0d", a.is_prior, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tdata[OUT_DATA_W-1:PROB_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[OUT_DATA_W-1:PROB_W]);
          fail_count++;
        end
      end
      rx_hold <= pace_receiver ? $urandom_range(0, 18) : 0;
    end
  end

  // Receiver stall after each answer
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Queries before any image, ignored labels and the unused operation
  task automatic test_unseen_class();
    send_fields(OP_PRIOR, 0, 0, 0, 1'b0, 1'b0);
    send_fields(OP_LIKELY, 0, 0, 0, 1'b1, 1'b0);
    send_fields(OP_UNUSED, 5, 3, 3, 1'b1, 1'b1);
    send_fields(OP_TRAIN, 15, 0, 0, 1'b1, 1'b1);
    send_fields(OP_PRIOR, 15, 0, 0, 1'b0, 1'b0);
  endtask

  // Hand-built images: corners, out-of-range pixels, image in progress
  task automatic test_directed_images();
    send_fields(OP_TRAIN, 0, 0, 0, 1'b1, 1'b0);
    send_fields(OP_TRAIN, 0, IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1'b1, 1'b0);
    send_fields(OP_TRAIN, 0, 63, 0, 1'b1, 1'b0);
    // out-of-range pixel still completes the image
    send_fields(OP_TRAIN, 0, 0, 63, 1'b0, 1'b1);
    send_fields(OP_TRAIN, NUM_CLASSES - 1, IMAGE_SIDE - 1, 0, 1'b1, 1'b1);
    // second shaded hit before the image ends: tally above n_c
    send_fields(OP_TRAIN, 0, 0, 0, 1'b1, 1'b0);
    send_fields(OP_LIKELY, 0, 0, 0, 1'b1, 1'b0);
    send_fields(OP_LIKELY, 0, 0, 0, 1'b0, 1'b0);
    send_fields(OP_LIKELY, 0, IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1'b0, 1'b0);
    send_fields(OP_LIKELY, 0, IMAGE_SIDE, 5, 1'b1, 1'b0);
    send_fields(OP_LIKELY, 0, 5, 63, 1'b0, 1'b0);
    send_fields(OP_PRIOR, 0, 0, 0, 1'b0, 1'b0);
    send_fields(OP_PRIOR, NUM_CLASSES - 1, 0, 0, 1'b0, 1'b0);
    send_fields(OP_PRIOR, 4, 0, 0, 1'b0, 1'b0);
    send_fields(OP_LIKELY, 15, 0, 0, 1'b1, 1'b0);
    send_fields(OP_TRAIN, 0, 1, 1, 1'b0, 1'b1);
    send_fields(OP_LIKELY, 0, 0, 0, 1'b1, 1'b1);
    send_fields(OP_PRIOR, 0, 63, 63, 1'b1, 1'b1);
  endtask

  // Sparse random images mixed with queries and noise
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned kind;
    int unsigned npix;
    bit          drained;
    request_t    r;
    counted = 0;
    drained = 1'b0;
    hot_row[0] = 0;              hot_col[0] = 0;
    hot_row[1] = IMAGE_SIDE - 1; hot_col[1] = IMAGE_SIDE - 1;
    hot_row[2] = 0;              hot_col[2] = IMAGE_SIDE - 1;
    hot_row[3] = IMAGE_SIDE - 1; hot_col[3] = 0;
    for (int k = 4; k < 8; k++) begin
      hot_row[k] = POS_W'($urandom_range(0, IMAGE_SIDE - 1));
      hot_col[k] = POS_W'($urandom_range(0, IMAGE_SIDE - 1));
    end
    while (counted < RANDOM_ITEMS) begin
      // pacing changes now and then, leaving stretches without idling
      if ($urandom_range(0, 39) == 0) begin
        pace_sender   = $urandom_range(0, 3) != 0;
        pace_receiver = $urandom_range(0, 3) != 0;
      end
      if ((!drained && counted >= RANDOM_ITEMS / 2) || $urandom_range(0, 149) == 0) begin
        wait_drained();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // one image: a few pixels, usually closed by a last pixel
        r.op    = OP_TRAIN;
        r.label = ($urandom_range(0, 7) == 0) ? LABEL_W'($urandom_range(NUM_CLASSES, 15))
                                              : LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        npix = $urandom_range(1, 6);
        for (int k = 0; k < npix; k++) begin
          pick_position(r.row, r.col);
          r.shaded = $urandom_range(0, 9) < 7;
          r.last   = (k == npix - 1) && ($urandom_range(0, 9) != 0);
          send_request(r);
          if (r.label < NUM_CLASSES) counted++;
        end
      end else if (kind < 85) begin
        r.op    = ($urandom_range(0, 2) == 0) ? OP_PRIOR : OP_LIKELY;
        r.label = ($urandom_range(0, 7) == 0) ? LABEL_W'($urandom_range(NUM_CLASSES, 15))
                                              : LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        pick_position(r.row, r.col);
        r.shaded = 1'($urandom_range(0, 1));
        r.last   = 1'($urandom_range(0, 1));
        send_request(r);
        counted++;
      end else begin
        // unconstrained request, sometimes the unused operation
        r.op     = (kind >= 95) ? OP_UNUSED : OP_W'($urandom_range(0, 3));
        r.label  = LABEL_W'($urandom_range(0, 15));
        r.row    = POS_W'($urandom_range(0, 63));
        r.col    = POS_W'($urandom_range(0, 63));
        r.shaded = 1'($urandom_range(0, 1));
        r.last   = 1'($urandom_range(0, 1));
        send_request(r);
        if (r.op != OP_UNUSED && !(r.op == OP_TRAIN && r.label >= NUM_CLASSES)) counted++;
      end
    end
  endtask

  // Burst of single-pixel images of one class with no idling on either side
  task automatic test_image_burst();
    wait_drained();
    pace_sender   = 1'b0;
    pace_receiver = 1'b0;
    for (int unsigned k = 0; k < BURST_IMAGES; k++)
      send_fields(OP_TRAIN, NUM_CLASSES - 1, IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1'b1, 1'b1);
    pace_sender   = 1'b1;
    pace_receiver = 1'b1;
    send_fields(OP_PRIOR, NUM_CLASSES - 1, 0, 0, 1'b0, 1'b0);
    send_fields(OP_PRIOR, 0, 0, 0, 1'b0, 1'b0);
    send_fields(OP_LIKELY, NUM_CLASSES - 1, IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1'b1, 1'b0);
    send_fields(OP_LIKELY, NUM_CLASSES - 1, IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1'b0, 1'b0);
    send_fields(OP_LIKELY, NUM_CLASSES - 1, 0, 0, 1'b0, 1'b0);
  endtask

  // Test sequence
  initial begin
    foreach (shaded_tally[i]) shaded_tally[i] = '0;
    foreach (class_images[i]) class_images[i] = '0;
    images_total     = '0;
    classes_seen_cnt = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unseen_class();
    test_directed_images();
    test_random_traffic();
    test_image_burst();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
